@@ rtl/fslru_pkg.sv @@
`timescale 1ns / 1ps
package fslru_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int BATCH_STEP_DEF  = 100;

  localparam int KEY_W   = 64;
  localparam int CNT_W   = 32;
  localparam int RATIO_W = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int REG7_W  = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_DIFF   = 2'd2;

  localparam logic [1:0] REGION_MISS    = 2'd0;
  localparam logic [1:0] REGION_FROZEN  = 2'd1;
  localparam logic [1:0] REGION_DYNAMIC = 2'd2;

  localparam logic [CFG_W-1:0] CAPACITY_RST    = 16'd64;
  localparam logic [CFG_W-1:0] SPLIT_COUNT_RST = 16'd49;
  localparam logic [CFG_W-1:0] MISS_DIFF_RST   = 16'd655;

  typedef struct packed {
    logic shift;
    logic take_new;
  } cell_ctl_t;

endpackage

@@ rtl/fslru_key_if.sv @@
`timescale 1ns / 1ps
interface fslru_key_if;
  logic                        valid;
  logic                        ready;
  logic [fslru_pkg::KEY_W-1:0] key;
  modport source (output valid, output key, input ready);
  modport sink (input valid, input key, output ready);
endinterface

@@ rtl/fslru_res_if.sv @@
`timescale 1ns / 1ps
interface fslru_res_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] hit_region;
  logic       frozen_mode;
  modport source (output valid, output hit, output hit_region, output frozen_mode,
                  input ready);
  modport sink (input valid, input hit, input hit_region, input frozen_mode,
                output ready);
endinterface

@@ rtl/frozen_split_lru_cache_policy_unit.sv @@
`timescale 1ns / 1ps
// Frozen-hot LRU policy unit. One key enters per transfer on in_ch and one result
// leaves per transfer on out_ch: hit flag, hit region and the mode after the access.
// Entries sit in a row of cells ordered from most to least recently used; a
// reorder or an insertion shifts a span of cells one place toward the tail.
// A hit passes through take, compare in all cells, resolve, count, check and output.
// A miss adds an insert step, and one more per evicted entry when the cache is full.
// The access that freezes the cache adds the bit-serial ratio divider unless the
// ratio saturates, and each frozen access adds a step for the melt compare.
// Items are handled one at a time; a new key is taken as soon as the previous one
// has reached the output register, even while that result waits for the receiver.
// When the receiver stalls with a result pending, the next result waits in the
// final state until the output register is free.
// Configuration writes on cfg_we/cfg_idx/cfg_wdata act at once; the user must make them
// only while the unit is idle, as the block does not enforce it. Synchronous reset
// empties the cache, clears all counters and returns to regular mode; no clearing pass is needed.
module frozen_split_lru_cache_policy_unit #(
  parameter int MAX_ENTRIES = fslru_pkg::MAX_ENTRIES_DEF,
  parameter int BATCH_STEP  = fslru_pkg::BATCH_STEP_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fslru_key_if.sink                       in_ch,
  fslru_res_if.source                     out_ch,
  input  logic                            cfg_we,
  input  logic [fslru_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [fslru_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CW = ($clog2(MAX_ENTRIES + 1) > 7) ? $clog2(MAX_ENTRIES + 1) : 7;
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int KW = fslru_pkg::KEY_W;
  localparam int NW = fslru_pkg::CNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CMP  = 4'd1;
  localparam logic [3:0] S_RES  = 4'd2;
  localparam logic [3:0] S_EVC  = 4'd3;
  localparam logic [3:0] S_STAT = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MEL  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]    state_r;
  logic [KW-1:0] key_r;
  logic [MAX_ENTRIES-1:0] match_r;
  logic          hit_r;
  logic [1:0]    region_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] fz_r;
  logic [CW-1:0] k_r;
  logic          frozen_r;
  logic [15:0]   ratio_r;
  logic [NW-1:0] den_r;
  logic [NW-1:0] rem_r;
  logic [15:0]   q_r;
  logic [3:0]    bit_r;
  logic [48:0]   prod_r;
  logic [6:0]    cap_cfg_r;
  logic [6:0]    split_r;
  logic [15:0]   mdiff_r;
  logic          out_valid_r;
  logic          out_hit_r;
  logic [1:0]    out_region_r;
  logic          out_frozen_r;

  logic [KW-1:0] cell_key [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_match;
  fslru_pkg::cell_ctl_t cell_ctl [MAX_ENTRIES];

  logic [NW-1:0] racc, rmiss, facc, fmiss;
  logic          bump_racc, bump_rmiss, bump_facc, bump_fmiss;
  logic          clr_reg, freeze_do, melt_do;

  logic [CW-1:0] cap_c, split_c, kk_c, f_c;
  logic [IW-1:0] f_idx;
  logic          any_c;
  logic          sh_go;
  logic [CW-1:0] sh_lo, sh_hi;
  logic          fr_go;
  logic [NW-1:0] den_c;
  logic [NW:0]   rem_sh;
  logic [16:0]   lim_c;
  logic [48:0]   prod_c;

  always_comb begin
    if (cap_cfg_r == 7'd0) begin
      cap_c = CW'(1);
    end else if (CW'(cap_cfg_r) > CW'(MAX_ENTRIES)) begin
      cap_c = CW'(MAX_ENTRIES);
    end else begin
      cap_c = CW'(cap_cfg_r);
    end
  end

  assign split_c = CW'(split_r);

  always_comb begin
    f_idx = '0;
    for (int b = 0; b < IW; b++) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (((i >> b) & 1) == 1) begin
          f_idx[b] = f_idx[b] | match_r[i];
        end
      end
    end
  end

  assign any_c = |match_r;
  assign f_c   = CW'(f_idx);

  always_comb begin
    sh_go = 1'b0;
    sh_lo = '0;
    sh_hi = '0;
    if (state_r == S_RES && any_c && !frozen_r) begin
      sh_go = 1'b1;
      sh_hi = f_c;
    end else if (state_r == S_EVC && count_r < cap_c) begin
      sh_go = 1'b1;
      sh_lo = fz_r;
      sh_hi = count_r;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      logic [KW-1:0] left_key;
      if (gi == 0) begin : g_first
        assign left_key = key_r;
      end else begin : g_rest
        assign left_key = cell_key[gi-1];
      end
      assign cell_ctl[gi].shift    = sh_go && (CW'(gi) >= sh_lo) && (CW'(gi) <= sh_hi);
      assign cell_ctl[gi].take_new = (CW'(gi) == sh_lo);
      fslru_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[gi]),
        .new_key   (key_r),
        .left_key  (left_key),
        .probe_key (key_r),
        .occupied  (CW'(gi) < count_r),
        .key       (cell_key[gi]),
        .match     (cell_match[gi])
      );
    end
  endgenerate

  assign bump_racc  = (state_r == S_CMP) && !frozen_r;
  assign bump_facc  = (state_r == S_CMP) && frozen_r;
  assign bump_rmiss = (state_r == S_STAT) && !hit_r && !frozen_r && (racc > NW'(cap_c));
  assign bump_fmiss = (state_r == S_STAT) && !hit_r && frozen_r;

  always_comb begin
    kk_c = '0;
    if (count_r != '0) begin
      kk_c = (split_c > count_r - CW'(1)) ? count_r - CW'(1) : split_c;
    end
  end

  assign fr_go = !frozen_r && ({1'b0, racc} >= ((NW + 1)'(cap_c) << 1)) &&
                 (count_r >= split_c) && (kk_c != '0);
  assign den_c  = racc - NW'(cap_c);
  assign rem_sh = {rem_r, 1'b0};
  assign lim_c  = {1'b0, ratio_r} + {1'b0, mdiff_r};
  assign prod_c = lim_c * facc;

  assign freeze_do = (state_r == S_CHK && fr_go && rmiss >= den_c) ||
                     (state_r == S_DIV && bit_r == 4'd0);
  assign melt_do   = (state_r == S_MEL) && (facc > NW'(cap_c)) &&
                     ({1'b0, fmiss, 16'd0} > prod_r);
  assign clr_reg   = freeze_do || melt_do;

  fslru_batch_ctr #(.BATCH_STEP(BATCH_STEP)) u_racc (
    .clk(clk), .rst_n(rst_n), .bump(bump_racc), .clr(clr_reg), .count(racc));
  fslru_batch_ctr #(.BATCH_STEP(BATCH_STEP)) u_rmiss (
    .clk(clk), .rst_n(rst_n), .bump(bump_rmiss), .clr(clr_reg), .count(rmiss));
  fslru_batch_ctr #(.BATCH_STEP(BATCH_STEP)) u_facc (
    .clk(clk), .rst_n(rst_n), .bump(bump_facc), .clr(freeze_do), .count(facc));
  fslru_batch_ctr #(.BATCH_STEP(BATCH_STEP)) u_fmiss (
    .clk(clk), .rst_n(rst_n), .bump(bump_fmiss), .clr(freeze_do), .count(fmiss));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_cfg_r <= fslru_pkg::CAPACITY_RST[6:0];
      split_r   <= fslru_pkg::SPLIT_COUNT_RST[6:0];
      mdiff_r   <= fslru_pkg::MISS_DIFF_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fslru_pkg::CFG_CAPACITY:    cap_cfg_r <= cfg_wdata[6:0];
        fslru_pkg::CFG_SPLIT_COUNT: split_r   <= cfg_wdata[6:0];
        fslru_pkg::CFG_MISS_DIFF:   mdiff_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fz_r        <= '0;
      frozen_r    <= 1'b0;
      ratio_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      if (freeze_do) begin
        fz_r     <= (state_r == S_DIV) ? k_r : kk_c;
        frozen_r <= 1'b1;
        ratio_r  <= (state_r == S_DIV) ? {q_r[14:0], (rem_sh >= {1'b0, den_r})} : 16'hFFFF;
      end
      if (melt_do) begin
        fz_r     <= '0;
        frozen_r <= 1'b0;
        ratio_r  <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            key_r   <= in_ch.key;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          match_r <= cell_match;
          state_r <= S_RES;
        end
        S_RES: begin
          hit_r <= any_c;
          if (!any_c) begin
            region_r <= fslru_pkg::REGION_MISS;
            state_r  <= S_EVC;
          end else begin
            region_r <= (f_c < fz_r) ? fslru_pkg::REGION_FROZEN : fslru_pkg::REGION_DYNAMIC;
            state_r  <= S_STAT;
          end
        end
        S_EVC: begin
          if (count_r >= cap_c && count_r > fz_r) begin
            count_r <= count_r - CW'(1);
          end else begin
            if (count_r < cap_c) begin
              count_r <= count_r + CW'(1);
            end
            state_r <= S_STAT;
          end
        end
        S_STAT: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          k_r    <= kk_c;
          den_r  <= den_c;
          rem_r  <= rmiss;
          q_r    <= '0;
          bit_r  <= 4'd15;
          prod_r <= prod_c;
          if (frozen_r) begin
            state_r <= S_MEL;
          end else if (fr_go && rmiss < den_c) begin
            state_r <= S_DIV;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, den_r}) begin
            rem_r <= NW'(rem_sh - {1'b0, den_r});
            q_r   <= {q_r[14:0], 1'b1};
          end else begin
            rem_r <= rem_sh[NW-1:0];
            q_r   <= {q_r[14:0], 1'b0};
          end
          bit_r <= bit_r - 4'd1;
          if (bit_r == 4'd0) begin
            state_r <= S_OUT;
          end
        end
        S_MEL: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_hit_r    <= hit_r;
            out_region_r <= region_r;
            out_frozen_r <= frozen_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.hit_region  = out_region_r;
  assign out_ch.frozen_mode = out_frozen_r;

endmodule

@@ rtl/fslru_cell.sv @@
`timescale 1ns / 1ps
module fslru_cell (
  input  logic                        clk,
  input  fslru_pkg::cell_ctl_t        ctl,
  input  logic [fslru_pkg::KEY_W-1:0] new_key,
  input  logic [fslru_pkg::KEY_W-1:0] left_key,
  input  logic [fslru_pkg::KEY_W-1:0] probe_key,
  input  logic                        occupied,
  output logic [fslru_pkg::KEY_W-1:0] key,
  output logic                        match
);

  logic [fslru_pkg::KEY_W-1:0] key_r;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r <= ctl.take_new ? new_key : left_key;
    end
  end

  assign key   = key_r;
  assign match = occupied && (key_r == probe_key);

endmodule

@@ rtl/fslru_batch_ctr.sv @@
`timescale 1ns / 1ps
module fslru_batch_ctr #(
  parameter int BATCH_STEP = fslru_pkg::BATCH_STEP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        bump,
  input  logic                        clr,
  output logic [fslru_pkg::CNT_W-1:0] count
);

  localparam int RW = $clog2(BATCH_STEP + 1);

  logic [RW-1:0]               residue_r;
  logic [fslru_pkg::CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      residue_r <= '0;
      count_r   <= '0;
    end else if (clr) begin
      count_r <= '0;
    end else if (bump) begin
      if (residue_r == RW'(BATCH_STEP - 1)) begin
        residue_r <= '0;
        if (count_r > ({fslru_pkg::CNT_W{1'b1}} - fslru_pkg::CNT_W'(BATCH_STEP))) begin
          count_r <= '1;
        end else begin
          count_r <= count_r + fslru_pkg::CNT_W'(BATCH_STEP);
        end
      end else begin
        residue_r <= residue_r + RW'(1);
      end
    end
  end

  assign count = count_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  localparam int NENT = 64;
  localparam int STEP = 100;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic       hit;
    logic [1:0] region;
    logic       frozen;
  } access_res_t;

  typedef struct {
    logic [63:0] key;
    bit          typed;
    access_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [fslru_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [fslru_pkg::CFG_W-1:0] cfg_wdata;

  fslru_key_if in_ch();
  fslru_res_if out_ch();

  frozen_split_lru_cache_policy_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the cache state.
  logic [63:0] ent_key[NENT];
  bit ent_vld[NENT];
  bit ent_frz[NENT];
  logic [5:0] nxt[NENT];
  logic [5:0] prv[NENT];
  logic [5:0] head_f, tail_f, head_d, tail_d;
  int unsigned n_ent, n_frz;
  bit frozen_st;
  logic [31:0] stat[4];
  int unsigned resid[4];
  logic [31:0] ratio;
  int unsigned cap_r, split_r, diff_r;

  access_res_t results_due[$];
  int errors = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  logic [63:0] pool[96];

  function automatic int unsigned cap_eff();
    if (cap_r < 1) return 1;
    if (cap_r > NENT) return NENT;
    return cap_r;
  endfunction

  function automatic void bump(int w);
    resid[w]++;
    if (resid[w] >= STEP) begin
      resid[w] = 0;
      if (stat[w] > 32'hFFFF_FFFF - STEP) stat[w] = 32'hFFFF_FFFF;
      else stat[w] = stat[w] + STEP;
    end
  endfunction

  function automatic int lookup(logic [63:0] k, bit want);
    for (int i = 0; i < NENT; i++)
      if (ent_vld[i] && ent_frz[i] == want && ent_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void to_front(int i);
    logic [5:0] p, n, h;
    h = head_d;
    if (i == h) return;
    p = prv[i];
    if (i == tail_d) begin
      tail_d = p;
    end else begin
      n = nxt[i];
      prv[n] = p;
      nxt[p] = n;
    end
    nxt[i] = h;
    prv[h] = 6'(i);
    head_d = 6'(i);
  endfunction

  function automatic void fill_miss(logic [63:0] k);
    int unsigned c;
    c = cap_eff();
    while (n_ent >= c && n_ent - n_frz > 0) begin
      ent_vld[tail_d] = 1'b0;
      if (n_ent - n_frz > 1) tail_d = prv[tail_d];
      n_ent--;
    end
    if (n_ent >= c) return;
    for (int i = 0; i < NENT; i++) begin
      if (!ent_vld[i]) begin
        ent_key[i] = k;
        ent_vld[i] = 1'b1;
        ent_frz[i] = 1'b0;
        if (n_ent - n_frz == 0) begin
          head_d = 6'(i);
          tail_d = 6'(i);
        end else begin
          nxt[i] = head_d;
          prv[head_d] = 6'(i);
          head_d = 6'(i);
        end
        prv[i] = 6'(i);
        n_ent++;
        return;
      end
    end
  endfunction

  function automatic void do_freeze();
    int unsigned d, k;
    logic [5:0] cur, last;
    logic [63:0] den, r;
    d = n_ent - n_frz;
    if (d == 0) return;
    k = split_r;
    if (k > d - 1) k = d - 1;
    if (k == 0) return;
    den = {32'd0, stat[0]} - 64'(cap_eff());
    if (den == 0) den = 1;
    r = {16'd0, stat[1], 16'd0} / den;
    ratio = (r > 65535) ? 32'd65535 : r[31:0];
    stat[0] = 0;
    stat[1] = 0;
    cur = head_d;
    last = cur;
    head_f = cur;
    for (int j = 0; j < k; j++) begin
      ent_frz[cur] = 1'b1;
      last = cur;
      cur = nxt[cur];
    end
    tail_f = last;
    head_d = cur;
    n_frz = k;
    stat[2] = 0;
    stat[3] = 0;
    frozen_st = 1'b1;
  endfunction

  function automatic void do_melt();
    if (n_frz > 0) begin
      if (n_ent - n_frz > 0) begin
        nxt[tail_f] = head_d;
        prv[head_d] = tail_f;
      end else begin
        tail_d = tail_f;
      end
      head_d = head_f;
    end
    for (int i = 0; i < NENT; i++) ent_frz[i] = 1'b0;
    n_frz = 0;
    stat[0] = 0;
    stat[1] = 0;
    ratio = 0;
    frozen_st = 1'b0;
  endfunction

  function automatic access_res_t access_cache(logic [63:0] k);
    access_res_t o;
    int f;
    logic [63:0] acc;
    int unsigned c;
    c = cap_eff();
    o = '0;
    if (!frozen_st) begin
      bump(0);
      f = lookup(k, 1'b0);
      if (f >= 0) begin
        to_front(f);
        o.hit = 1'b1;
        o.region = fslru_pkg::REGION_DYNAMIC;
      end else begin
        fill_miss(k);
        if (stat[0] > c) bump(1);
      end
      if ({32'd0, stat[0]} >= 64'(2 * c) && n_ent >= split_r) do_freeze();
    end else begin
      bump(2);
      if (lookup(k, 1'b1) >= 0) begin
        o.hit = 1'b1;
        o.region = fslru_pkg::REGION_FROZEN;
      end else if (lookup(k, 1'b0) >= 0) begin
        o.hit = 1'b1;
        o.region = fslru_pkg::REGION_DYNAMIC;
      end else begin
        fill_miss(k);
        bump(3);
      end
      acc = {32'd0, stat[2]};
      if (acc > 64'(c) &&
          ({16'd0, stat[3], 16'd0} > ({32'd0, ratio} + 64'(diff_r)) * acc))
        do_melt();
    end
    o.frozen = frozen_st;
    return o;
  endfunction

  function automatic void cache_reset();
    for (int i = 0; i < NENT; i++) begin
      ent_key[i] = 0;
      ent_vld[i] = 0;
      ent_frz[i] = 0;
      nxt[i] = 0;
      prv[i] = 0;
    end
    for (int i = 0; i < 4; i++) begin
      stat[i] = 0;
      resid[i] = 0;
    end
    {head_f, tail_f, head_d, tail_d} = '0;
    n_ent = 0;
    n_frz = 0;
    frozen_st = 0;
    ratio = 0;
    cap_r = 32'(fslru_pkg::CAPACITY_RST);
    split_r = 32'(fslru_pkg::SPLIT_COUNT_RST);
    diff_r = 32'(fslru_pkg::MISS_DIFF_RST);
  endfunction

  task automatic write_settings(int unsigned c, int unsigned s, int unsigned d);
    cfg_we <= 1'b1;
    cfg_idx <= fslru_pkg::CFG_CAPACITY;
    cfg_wdata <= fslru_pkg::CFG_W'(c);
    @(posedge clk);
    cfg_idx <= fslru_pkg::CFG_SPLIT_COUNT;
    cfg_wdata <= fslru_pkg::CFG_W'(s);
    @(posedge clk);
    cfg_idx <= fslru_pkg::CFG_MISS_DIFF;
    cfg_wdata <= fslru_pkg::CFG_W'(d);
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_r = c & 32'h7F;
    split_r = s & 32'h7F;
    diff_r = d & 32'hFFFF;
  endtask

  // Drives one key and records its expected result once the transfer happens.
  task automatic send_key(logic [63:0] k, bit typed, access_res_t typed_res);
    int unsigned gap;
    access_res_t pred;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.key <= k;
    do @(posedge clk); while (!in_ch.ready);
    pred = access_cache(k);
    results_due.push_back(typed ? typed_res : pred);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      int unsigned stall;
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 8);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with no access pending");
        errors++;
      end else begin
        access_res_t e;
        e = results_due.pop_front();
        if (out_ch.hit !== e.hit) begin
          $error("hit: expected %0d, got %0d", e.hit, out_ch.hit);
          errors++;
        end
        if (out_ch.hit_region !== e.region) begin
          $error("hit_region: expected %0d, got %0d", e.region, out_ch.hit_region);
          errors++;
        end
        if (out_ch.frozen_mode !== e.frozen) begin
          $error("frozen_mode: expected %0d, got %0d", e.frozen, out_ch.frozen_mode);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    int unsigned settings[7][3];
    int unsigned hot, pick;
    logic [63:0] k;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= fslru_pkg::CFG_CAPACITY;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.key <= '0;
    cache_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows = '{
      '{64'd0, 1'b1, '{1'b0, fslru_pkg::REGION_MISS, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b0, fslru_pkg::REGION_MISS, 1'b0}},
      '{64'd0, 1'b1, '{1'b1, fslru_pkg::REGION_DYNAMIC, 1'b0}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, fslru_pkg::REGION_DYNAMIC, 1'b0}},
      '{64'h5555_5555_5555_5555, 1'b1, '{1'b0, fslru_pkg::REGION_MISS, 1'b0}},
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b1, '{1'b0, fslru_pkg::REGION_MISS, 1'b0}},
      '{64'h5555_5555_5555_5555, 1'b0, '0},
      '{64'd1, 1'b0, '0},
      '{64'h8000_0000_0000_0000, 1'b0, '0},
      '{64'd0, 1'b0, '0}
    };
    foreach (rows[i]) send_key(rows[i].key, rows[i].typed, rows[i].res);
    drain();

    settings = '{'{64, 49, 655}, '{1, 0, 0}, '{64, 64, 65535}, '{8, 4, 0},
                 '{32, 31, 655}, '{0, 127, 1}, '{127, 1, 300}};
    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) write_settings(settings[ph][0], settings[ph][1], settings[ph][2]);
      quiet = (ph % 3 == 1);
      foreach (pool[i]) pool[i] = {$urandom, $urandom};
      hot = 8;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 60 == 0) hot = $urandom_range(1, 2 * cap_eff() + 8);
        if (hot > 96) hot = 96;
        if (ph == 2 && n == 20) hold_req = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 85) k = pool[$urandom_range(0, hot - 1)];
        else if (pick < 95) k = {$urandom, $urandom};
        else k = pick[0] ? 64'd0 : 64'hFFFF_FFFF_FFFF_FFFF;
        send_key(k, 1'b0, '0);
      end
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
